// File: src/hdru_pkg.sv
// Package for the Hopfield delta rule engine: field widths, operation and
// register codes, reset values and default sizes.
// Depends on nothing; the interfaces, the engine top and the testbench use it.
`default_nettype none

package hdru_pkg;

  // Default sizes of the network and of one weight.
  localparam int MAX_UNITS_DEF   = 128;
  localparam int WEIGHT_BITS_DEF = 16;

  // Weights handled per memory word, and its log.
  localparam int LANES     = 8;
  localparam int LANE_BITS = 3;

  // Widths of the channel fields.
  localparam int FUNC_W     = 2;
  localparam int UNIT_IDX_W = 7;
  localparam int NOISE_W    = 16;
  localparam int FIELD_W    = 24;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 2;

  // Width of the signed weight step 2*eta.
  localparam int STEP_W = CFG_W + 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELAX = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TRAIN = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_UNITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd1;

  // Register reset values.
  localparam logic [CFG_W-1:0] UNITS_RST = 8'd100;
  localparam logic [CFG_W-1:0] RATE_RST  = 8'd26;

endpackage

`default_nettype wire

// File: src/hdru_if.sv
// Channel interfaces of the Hopfield engine: item input, result output and
// register write. Each carries valid, ready and its payload.
// Depends on hdru_pkg for the field widths.
`default_nettype none

interface hdru_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [hdru_pkg::FUNC_W-1:0]           func;
  logic [hdru_pkg::UNIT_IDX_W-1:0]       unit_index;
  logic                                  cue_bit;
  logic                                  target_bit;
  logic signed [hdru_pkg::NOISE_W-1:0]   field_noise;

  modport source (output valid, func, unit_index, cue_bit, target_bit, field_noise,
                  input ready);
  modport sink   (input valid, func, unit_index, cue_bit, target_bit, field_noise,
                  output ready);
endinterface

interface hdru_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  unit_state;
  logic                                  changed;
  logic                                  error_made;
  logic signed [hdru_pkg::FIELD_W-1:0]   local_field;

  modport source (output valid, unit_state, changed, error_made, local_field,
                  input ready);
  modport sink   (input valid, unit_state, changed, error_made, local_field,
                  output ready);
endinterface

interface hdru_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [hdru_pkg::CFG_IDX_W-1:0]        index;
  logic [hdru_pkg::CFG_W-1:0]            data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/hdru_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Used for the weight store; no dependencies.
`default_nettype none

module hdru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered output.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/hopfield_delta_rule_unit_engine.sv
// Top level of the bipolar Hopfield engine with delta rule training.
// Depends on hdru_pkg, the interfaces in hdru_if and the RAM in hdru_ram.
//
//   channel  | direction | word carried
//   ---------+-----------+-------------------------------------------------
//   cfg_i    | in        | register index and 8-bit value
//   in_i     | in        | func, unit_index, cue_bit, target_bit, field_noise
//   out_o    | out       | unit_state, changed, error_made, local_field
//
// A load or no-op word goes from idle straight to the done state. A relax or
// train word streams the weight row out of the RAM one 8-weight word per cycle,
// WORDS = ceil(MAX_UNITS/8) words, and the eight lane sums are then folded one
// per cycle. A train word that misses its target streams the row again for
// write-back. After reset the weight RAM is cleared one word per cycle, with
// in_i.ready low; register writes are taken.
// A new word is accepted while the previous result waits on out_o.ready.
`default_nettype none

module hopfield_delta_rule_unit_engine #(
  parameter int MAX_UNITS   = hdru_pkg::MAX_UNITS_DEF,
  parameter int WEIGHT_BITS = hdru_pkg::WEIGHT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hdru_cfg_if.sink   cfg_i,
  hdru_in_if.sink    in_i,
  hdru_out_if.source out_o
);

  import hdru_pkg::*;

  // Sizes derived from the network size.
  localparam int WORDS  = (MAX_UNITS + LANES - 1) / LANES;
  localparam int PAD    = WORDS * LANES;
  localparam int PIW    = $clog2(PAD);
  localparam int DEPTH  = MAX_UNITS * WORDS;
  localparam int MAW    = $clog2(DEPTH);
  localparam int WCW    = $clog2(WORDS + 1);
  localparam int UW_RAW = $clog2(MAX_UNITS) + 1;
  localparam int UW     = (UW_RAW > CFG_W) ? UW_RAW : CFG_W;
  localparam int LAW    = WEIGHT_BITS + $clog2(WORDS) + 1;
  localparam int AW_RAW = WEIGHT_BITS + $clog2(PAD) + 2;
  localparam int AW     = (AW_RAW > FIELD_W + 1) ? AW_RAW : FIELD_W + 1;
  localparam int UPW    = ((WEIGHT_BITS > STEP_W) ? WEIGHT_BITS : STEP_W) + 1;
  localparam int RW     = LANES * WEIGHT_BITS;

  localparam logic signed [AW-1:0]  FLD_HI = AW'((64'sd1 <<< (FIELD_W - 1)) - 64'sd1);
  localparam logic signed [AW-1:0]  FLD_LO = ~FLD_HI;
  localparam logic signed [UPW-1:0] W_HI   = UPW'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [UPW-1:0] W_LO   = ~W_HI;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIELD,
    ST_REDUCE,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_e;

  state_e                   state_q;
  logic [CFG_W-1:0]         units_q;
  logic [CFG_W-1:0]         rate_q;
  logic [PAD-1:0]           x_q;
  logic [PAD-1:0]           t_q;
  logic [FUNC_W-1:0]        func_q;
  logic [UW-1:0]            idx_q;
  logic signed [NOISE_W-1:0] noise_q;
  logic [MAW-1:0]           base_q;
  logic                     in_rng_q;
  logic [WCW-1:0]           iss_q;
  logic [WCW-1:0]           cons_q;
  logic                     rv_q;
  logic signed [LAW-1:0]    acc_q [LANES];
  logic [LANE_BITS-1:0]     red_q;
  logic signed [AW-1:0]     total_q;
  logic                     cap_x_q;
  logic                     cap_t_q;
  logic                     res_st_q;
  logic                     res_chg_q;
  logic                     res_err_q;
  logic signed [FIELD_W-1:0] res_fld_q;
  logic                     out_valid_q;
  logic                     out_st_q;
  logic                     out_chg_q;
  logic                     out_err_q;
  logic signed [FIELD_W-1:0] out_fld_q;
  logic [MAW-1:0]           clr_q;

  logic [UW-1:0]            n_u;
  logic [UW-1:0]            in_idx_u;
  logic                     pass;
  logic                     consume;
  logic                     ram_re;
  logic [MAW-1:0]           ram_raddr;
  logic                     ram_we;
  logic [MAW-1:0]           ram_waddr;
  logic [RW-1:0]            ram_wdata;
  logic [RW-1:0]            ram_rdata;
  logic [RW-1:0]            upd_word;
  logic [UW-1:0]            lane_j [LANES];
  logic signed [WEIGHT_BITS-1:0] lane_w [LANES];
  logic signed [LAW-1:0]    lane_term [LANES];
  logic signed [STEP_W-1:0] step_s;
  logic                     nb_sign;
  logic signed [FIELD_W-1:0] fld_sat;

  // Active unit count, clamped to the network size.
  assign n_u = (UW'(units_q) > UW'(MAX_UNITS)) ? UW'(MAX_UNITS) : UW'(units_q);
  assign in_idx_u = UW'(in_i.unit_index);

  // Row streaming: reads are issued ahead, each word is consumed in the cycle after its read.
  assign pass      = (state_q == ST_FIELD) || (state_q == ST_UPDATE);
  assign consume   = pass && rv_q;
  assign ram_re    = pass && (iss_q < WCW'(WORDS)) && in_rng_q;
  assign ram_raddr = base_q + MAW'(iss_q);

  // Write side: clearing sweep after reset, or row write-back during training.
  assign ram_we    = (state_q == ST_CLEAR) || (consume && (state_q == ST_UPDATE));
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : base_q + MAW'(cons_q);
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : upd_word;

  assign step_s = {1'b0, rate_q, 1'b0};

  // Per-lane unit number, weight and signed contribution to the field.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_j[k]    = UW'(cons_q) * UW'(LANES) + UW'(k);
      lane_w[k]    = ram_rdata[k*WEIGHT_BITS +: WEIGHT_BITS];
      lane_term[k] = x_q[k] ? LAW'(lane_w[k]) : -LAW'(lane_w[k]);
    end
  end

  // Per-lane weight update: step toward the target, saturate, clear diagonal, keep inactive units.
  always_comb begin
    logic signed [UPW-1:0] sum;
    logic signed [WEIGHT_BITS-1:0] nw;
    upd_word = '0;
    for (int k = 0; k < LANES; k++) begin
      sum = UPW'(lane_w[k]) +
            ((x_q[k] == cap_t_q) ? UPW'(step_s) : -UPW'(step_s));
      if (sum > W_HI) begin
        nw = W_HI[WEIGHT_BITS-1:0];
      end else if (sum < W_LO) begin
        nw = W_LO[WEIGHT_BITS-1:0];
      end else begin
        nw = sum[WEIGHT_BITS-1:0];
      end
      if (lane_j[k] == idx_q) begin
        nw = '0;
      end else if (lane_j[k] >= n_u) begin
        nw = lane_w[k];
      end
      upd_word[k*WEIGHT_BITS +: WEIGHT_BITS] = nw;
    end
  end

  // Sign of the finished field and its saturated value.
  assign nb_sign = ~total_q[AW-1];
  always_comb begin
    if (total_q > FLD_HI) begin
      fld_sat = FLD_HI[FIELD_W-1:0];
    end else if (total_q < FLD_LO) begin
      fld_sat = FLD_LO[FIELD_W-1:0];
    end else begin
      fld_sat = total_q[FIELD_W-1:0];
    end
  end

  // Handshake outputs.
  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.unit_state  = out_st_q;
  assign out_o.changed     = out_chg_q;
  assign out_o.error_made  = out_err_q;
  assign out_o.local_field = out_fld_q;

  // Weight store, one word of LANES weights per address, row-major.
  hdru_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_weights (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // Controller, state vectors, accumulators and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      units_q     <= UNITS_RST;
      rate_q      <= RATE_RST;
      x_q         <= '0;
      t_q         <= '0;
      func_q      <= FUNC_NOP;
      idx_q       <= '0;
      noise_q     <= '0;
      base_q      <= '0;
      in_rng_q    <= 1'b0;
      iss_q       <= '0;
      cons_q      <= '0;
      rv_q        <= 1'b0;
      for (int k = 0; k < LANES; k++) begin
        acc_q[k] <= '0;
      end
      red_q       <= '0;
      total_q     <= '0;
      cap_x_q     <= 1'b0;
      cap_t_q     <= 1'b0;
      res_st_q    <= 1'b0;
      res_chg_q   <= 1'b0;
      res_err_q   <= 1'b0;
      res_fld_q   <= '0;
      out_valid_q <= 1'b0;
      out_st_q    <= 1'b0;
      out_chg_q   <= 1'b0;
      out_err_q   <= 1'b0;
      out_fld_q   <= '0;
      clr_q       <= '0;
    end else begin
      // Register writes; unknown indexes are dropped.
      if (cfg_i.valid) begin
        if (cfg_i.index == CFG_UNITS) begin
          units_q <= cfg_i.data;
        end else if (cfg_i.index == CFG_RATE) begin
          rate_q <= cfg_i.data;
        end
      end

      // Result taken downstream; a waiting result refills the register instead.
      if (out_valid_q && out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      // Read issue and word consumption shared by both row passes.
      if (pass) begin
        if (iss_q < WCW'(WORDS)) begin
          iss_q <= iss_q + 1'b1;
          rv_q  <= 1'b1;
        end else begin
          rv_q  <= 1'b0;
        end
        if (consume) begin
          x_q    <= {x_q[LANES-1:0], x_q[PAD-1:LANES]};
          t_q    <= {t_q[LANES-1:0], t_q[PAD-1:LANES]};
          cons_q <= cons_q + 1'b1;
        end
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == MAW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_i.valid) begin
            func_q    <= in_i.func;
            idx_q     <= in_idx_u;
            noise_q   <= in_i.field_noise;
            base_q    <= MAW'(int'(in_i.unit_index) * WORDS);
            in_rng_q  <= (in_idx_u < n_u) &&
                         ((in_i.func == FUNC_RELAX) || (in_i.func == FUNC_TRAIN));
            iss_q     <= '0;
            cons_q    <= '0;
            rv_q      <= 1'b0;
            cap_x_q   <= 1'b0;
            cap_t_q   <= 1'b0;
            for (int k = 0; k < LANES; k++) begin
              acc_q[k] <= '0;
            end
            res_st_q  <= (in_i.func == FUNC_LOAD) ? in_i.cue_bit : 1'b0;
            res_chg_q <= 1'b0;
            res_err_q <= 1'b0;
            res_fld_q <= '0;
            if (in_i.func == FUNC_LOAD) begin
              if (in_idx_u < UW'(MAX_UNITS)) begin
                x_q[in_idx_u[PIW-1:0]] <= in_i.cue_bit;
                t_q[in_idx_u[PIW-1:0]] <= in_i.target_bit;
              end
              state_q  <= ST_DONE;
            end else if (in_i.func == FUNC_NOP) begin
              state_q  <= ST_DONE;
            end else begin
              state_q  <= ST_FIELD;
            end
          end
        end

        ST_FIELD: begin
          if (consume) begin
            // Pick up the unit's own state and target as its word passes.
            if (UW'(cons_q) == (idx_q >> LANE_BITS)) begin
              cap_x_q <= x_q[idx_q[LANE_BITS-1:0]];
              cap_t_q <= t_q[idx_q[LANE_BITS-1:0]];
            end
            for (int k = 0; k < LANES; k++) begin
              if (in_rng_q && (lane_j[k] < n_u) && (lane_j[k] != idx_q)) begin
                acc_q[k] <= acc_q[k] + lane_term[k];
              end
            end
            if (cons_q == WCW'(WORDS - 1)) begin
              total_q <= (func_q == FUNC_TRAIN) ? AW'(noise_q) : '0;
              red_q   <= '0;
              state_q <= ST_REDUCE;
            end
          end
        end

        ST_REDUCE: begin
          // Fold the lane sums into the total, one lane per cycle.
          total_q <= total_q + AW'(acc_q[0]);
          for (int k = 0; k < LANES - 1; k++) begin
            acc_q[k] <= acc_q[k+1];
          end
          acc_q[LANES-1] <= '0;
          red_q <= red_q + 1'b1;
          if (red_q == LANE_BITS'(LANES - 1)) begin
            state_q <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          if (!in_rng_q) begin
            res_st_q <= cap_x_q;
            state_q  <= ST_DONE;
          end else if (func_q == FUNC_RELAX) begin
            res_st_q  <= nb_sign;
            res_chg_q <= nb_sign != cap_x_q;
            res_fld_q <= fld_sat;
            x_q[idx_q[PIW-1:0]] <= nb_sign;
            state_q   <= ST_DONE;
          end else begin
            res_st_q  <= nb_sign;
            res_fld_q <= fld_sat;
            if (nb_sign != cap_t_q) begin
              res_err_q <= 1'b1;
              iss_q     <= '0;
              cons_q    <= '0;
              rv_q      <= 1'b0;
              state_q   <= ST_UPDATE;
            end else begin
              state_q   <= ST_DONE;
            end
          end
        end

        ST_UPDATE: begin
          if (consume && (cons_q == WCW'(WORDS - 1))) begin
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          // Hand the result to the output register once it is free.
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_st_q    <= res_st_q;
            out_chg_q   <= res_chg_q;
            out_err_q   <= res_err_q;
            out_fld_q   <= res_fld_q;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The weight RAM is written only by the clearing sweep or a training pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_UPDATE))
    else $error("weight write outside clear or update");

  // Rows are read only for a unit inside the active range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> in_rng_q)
    else $error("weight read for an inactive unit");

  // The write-back pass only follows a train word that missed its target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> (res_err_q && func_q == FUNC_TRAIN && in_rng_q))
    else $error("row update without a training error");

  // A result never reports both a flip and a training error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_chg_q && out_err_q))
    else $error("result flags changed and error_made together");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Testbench for the Hopfield delta rule engine: drives load, relax, train and
// no-op words, predicts every result word and checks the output channel.
// Depends on hdru_pkg, the channel interfaces in hdru_if and the engine top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hdru_pkg::*;

  localparam int     NUM_UNITS    = MAX_UNITS_DEF;
  localparam int     W_BITS       = WEIGHT_BITS_DEF;
  localparam longint FIELD_HI     = 64'sd8388607;
  localparam longint FIELD_LO     = -64'sd8388608;
  localparam longint WEIGHT_HI    = 64'sd32767;
  localparam longint WEIGHT_LO    = -64'sd32768;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     TAIL_CYCLES  = 60;
  localparam int     MAX_REPORTS  = 100;
  localparam int     OPENING_ROWS = 22;

  // Register indexes that the engine does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic [UNIT_IDX_W-1:0]        unit_index;
    logic                         cue_bit;
    logic                         target_bit;
    logic signed [NOISE_W-1:0]    field_noise;
  } unit_word_t;

  typedef struct packed {
    logic                         unit_state;
    logic                         changed;
    logic                         error_made;
    logic signed [FIELD_W-1:0]    local_field;
  } unit_result_t;

  typedef struct packed {
    unit_word_t   word;
    logic         typed;
    unit_result_t want;
  } opening_row_t;

  logic clk_i;
  logic rst_ni;

  hdru_in_if  in_if ();
  hdru_out_if out_if ();
  hdru_cfg_if cfg_if ();

  hopfield_delta_rule_unit_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the engine state, updated in acceptance order.
  logic signed [W_BITS-1:0] syn_weight [NUM_UNITS][NUM_UNITS];
  logic [NUM_UNITS-1:0]     cue_state;
  logic [NUM_UNITS-1:0]     target_state;
  logic [CFG_W-1:0]         cfg_units;
  logic [CFG_W-1:0]         cfg_rate;

  unit_result_t awaited_results [$];
  unit_word_t   stim_q [$];

  bit          stall_enable;
  bit          hold_pending;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned reg_writes;
  int unsigned n_loads, n_relaxes, n_trains, n_nops, n_row_updates, n_clamps;

  // Opening words; typed expectations are the ones obvious from a cleared
  // engine at the reset settings (100 units, rate 26).
  opening_row_t opening_rows [OPENING_ROWS] = '{
    // Zero field counts as +1, so unit 0 flips up from its reset -1.
    '{'{FUNC_RELAX, 7'd0,   1'b0, 1'b0, 16'sd0},     1'b1, '{1'b1, 1'b1, 1'b0, 24'sd0}},
    '{'{FUNC_RELAX, 7'd0,   1'b0, 1'b0, 16'sd0},     1'b1, '{1'b1, 1'b0, 1'b0, 24'sd0}},
    '{'{FUNC_LOAD,  7'd5,   1'b1, 1'b1, 16'sd0},     1'b1, '{1'b1, 1'b0, 1'b0, 24'sd0}},
    // Loads reach the top unit whatever the unit count register holds.
    '{'{FUNC_LOAD,  7'd127, 1'b0, 1'b1, 16'sh7fff},  1'b1, '{1'b0, 1'b0, 1'b0, 24'sd0}},
    // Units beyond the active count only report their stored bit.
    '{'{FUNC_RELAX, 7'd127, 1'b0, 1'b0, 16'sd0},     1'b1, '0},
    '{'{FUNC_TRAIN, 7'd127, 1'b1, 1'b1, 16'sh8000},  1'b1, '0},
    '{'{FUNC_NOP,   7'h55,  1'b1, 1'b1, 16'sh5a5a},  1'b1, '0},
    // Extreme negative noise against a +1 target forces a row update.
    '{'{FUNC_TRAIN, 7'd5,   1'b0, 1'b0, 16'sh8000},  1'b1,
      '{1'b0, 1'b0, 1'b1, -24'sd32768}},
    '{'{FUNC_RELAX, 7'd5,   1'b0, 1'b0, 16'sd0},     1'b0, '0},
    '{'{FUNC_TRAIN, 7'd3,   1'b0, 1'b0, 16'sh7fff},  1'b1,
      '{1'b1, 1'b0, 1'b1, 24'sd32767}},
    '{'{FUNC_TRAIN, 7'd0,   1'b0, 1'b0, 16'sd0},     1'b1, '{1'b1, 1'b0, 1'b1, 24'sd0}},
    '{'{FUNC_RELAX, 7'd3,   1'b0, 1'b0, 16'sd0},     1'b0, '0},
    '{'{FUNC_LOAD,  7'd1,   1'b1, 1'b0, 16'sh7fff},  1'b1, '{1'b1, 1'b0, 1'b0, 24'sd0}},
    '{'{FUNC_TRAIN, 7'd1,   1'b0, 1'b0, 16'sh1234},  1'b0, '0},
    '{'{FUNC_RELAX, 7'd0,   1'b0, 1'b0, 16'sd0},     1'b0, '0},
    '{'{FUNC_TRAIN, 7'd5,   1'b1, 1'b0, 16'sd0},     1'b0, '0},
    '{'{FUNC_RELAX, 7'd99,  1'b0, 1'b0, 16'sd0},     1'b0, '0},
    '{'{FUNC_RELAX, 7'd100, 1'b1, 1'b1, 16'sd0},     1'b1, '0},
    '{'{FUNC_TRAIN, 7'd99,  1'b0, 1'b1, 16'sh8000},  1'b0, '0},
    '{'{FUNC_NOP,   7'd0,   1'b0, 1'b0, 16'sd0},     1'b1, '0},
    '{'{FUNC_LOAD,  7'd0,   1'b0, 1'b0, 16'sd0},     1'b1, '0},
    '{'{FUNC_RELAX, 7'd0,   1'b0, 1'b0, 16'sd0},     1'b0, '0}
  };

  // Works out the result of one word and applies its effect on the shadow state.
  function automatic unit_result_t neuron_update(input unit_word_t w);
    unit_result_t r;
    int unsigned  n;
    int unsigned  u;
    longint       h;
    longint       step;
    longint       nw;
    logic         fired;
    r = '0;
    u = 32'(w.unit_index);
    n = (cfg_units > NUM_UNITS) ? NUM_UNITS : 32'(cfg_units);
    case (w.func)
      FUNC_LOAD: begin
        cue_state[u]    = w.cue_bit;
        target_state[u] = w.target_bit;
        r.unit_state    = w.cue_bit;
      end
      FUNC_RELAX, FUNC_TRAIN: begin
        if (u >= n) begin
          r.unit_state = cue_state[u];
        end else begin
          h = 0;
          for (int j = 0; j < n; j++) begin
            if (j != u) begin
              h += cue_state[j] ? longint'(syn_weight[u][j]) : -longint'(syn_weight[u][j]);
            end
          end
          if (w.func == FUNC_TRAIN) begin
            h += longint'(w.field_noise);
          end
          fired = (h >= 0);
          r.unit_state  = fired;
          r.local_field = FIELD_W'((h > FIELD_HI) ? FIELD_HI : (h < FIELD_LO) ? FIELD_LO : h);
          if (w.func == FUNC_RELAX) begin
            r.changed    = (fired != cue_state[u]);
            cue_state[u] = fired;
          end else if (fired != target_state[u]) begin
            // Delta step of 2*eta toward the target, then the diagonal is cleared.
            step = 2 * longint'(cfg_rate);
            if (!target_state[u]) begin
              step = -step;
            end
            for (int j = 0; j < n; j++) begin
              nw = longint'(syn_weight[u][j]) + (cue_state[j] ? step : -step);
              if (nw > WEIGHT_HI) begin
                nw = WEIGHT_HI;
                n_clamps++;
              end else if (nw < WEIGHT_LO) begin
                nw = WEIGHT_LO;
                n_clamps++;
              end
              syn_weight[u][j] = W_BITS'(nw);
            end
            syn_weight[u][u] = '0;
            r.error_made     = 1'b1;
            n_row_updates++;
          end
        end
      end
      FUNC_NOP: ;
    endcase
    return r;
  endfunction

  function automatic unit_word_t pack_word(input logic [FUNC_W-1:0] func,
                                           input logic [UNIT_IDX_W-1:0] idx,
                                           input logic cue, input logic tgt,
                                           input logic signed [NOISE_W-1:0] noise);
    unit_word_t w;
    w.func        = func;
    w.unit_index  = idx;
    w.cue_bit     = cue;
    w.target_bit  = tgt;
    w.field_noise = noise;
    return w;
  endfunction

  // Appends one word to the end of the stimulus list.
  function automatic void add_word(input unit_word_t w);
    stim_q.insert(stim_q.size(), w);
  endfunction

  // Mostly small noise so that training converges, now and then any value.
  function automatic logic signed [NOISE_W-1:0] train_noise();
    if ($urandom_range(0, 4) == 0) begin
      return NOISE_W'($urandom);
    end
    return NOISE_W'($urandom_range(0, 1023)) - 16'sd512;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
               $realtime, what, results_checked, got, want);
    end
    mismatch_count++;
  endtask

  // Offers one word, waits for its handshake and records what it should give.
  task automatic offer_word(input unit_word_t w, input logic typed, input unit_result_t want);
    unit_result_t predicted;
    if (stall_enable && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= w.func;
    in_if.unit_index  <= w.unit_index;
    in_if.cue_bit     <= w.cue_bit;
    in_if.target_bit  <= w.target_bit;
    in_if.field_noise <= w.field_noise;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predicted = neuron_update(w);
    awaited_results.insert(awaited_results.size(), typed ? want : predicted);
    case (w.func)
      FUNC_LOAD:  n_loads++;
      FUNC_RELAX: n_relaxes++;
      FUNC_TRAIN: n_trains++;
      FUNC_NOP:   n_nops++;
    endcase
  endtask

  task automatic drive_all();
    foreach (stim_q[k]) begin
      offer_word(stim_q[k], 1'b0, '0);
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Register write; the caller lowers valid after the last one of a batch.
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    if (idx == CFG_UNITS) begin
      cfg_units = val;
    end else if (idx == CFG_RATE) begin
      cfg_rate = val;
    end
    reg_writes++;
  endtask

  // Settings change only once every result is back and the engine is idle.
  task automatic configure(input logic [CFG_W-1:0] units, input logic [CFG_W-1:0] rate,
                           input bit spare);
    wait_drained();
    repeat (4) @(posedge clk_i);
    reg_write(CFG_UNITS, units);
    reg_write(CFG_RATE, rate);
    if (spare) begin
      reg_write(CFG_SPARE_A, CFG_W'($urandom));
      reg_write(CFG_SPARE_B, CFG_W'($urandom));
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Training episodes (load a pattern, train, relax) mixed with loose words.
  task automatic build_mixed(input int unsigned count);
    int unsigned n;
    int unsigned k;
    n = (cfg_units > NUM_UNITS) ? NUM_UNITS : 32'(cfg_units);
    stim_q.delete();
    while (stim_q.size() < count) begin
      if (n != 0 && $urandom_range(0, 3) != 0) begin
        k = (n > 32) ? 32 : n;
        for (int j = 0; j < n; j++) begin
          add_word(pack_word(FUNC_LOAD, UNIT_IDX_W'(j), 1'($urandom), 1'($urandom),
                             NOISE_W'($urandom)));
        end
        repeat (k) begin
          add_word(pack_word(FUNC_TRAIN, UNIT_IDX_W'($urandom_range(0, n - 1)),
                             1'($urandom), 1'($urandom), train_noise()));
        end
        repeat (k) begin
          add_word(pack_word(FUNC_RELAX, UNIT_IDX_W'($urandom_range(0, n - 1)),
                             1'($urandom), 1'($urandom), NOISE_W'($urandom)));
        end
      end else begin
        repeat (8) begin
          add_word(pack_word(FUNC_W'($urandom_range(0, 3)), UNIT_IDX_W'($urandom),
                             1'($urandom), 1'($urandom), NOISE_W'($urandom)));
        end
      end
    end
    while (stim_q.size() > count) void'(stim_q.pop_back());
  endtask

  // Two units whose cue and target flip together each round, with noise that
  // always wins, so both off-diagonal weights run into their clamps.
  task automatic build_saturation(input int unsigned rounds);
    stim_q.delete();
    repeat (rounds) begin
      add_word(pack_word(FUNC_LOAD,  7'd1, 1'b1, 1'b0, 16'sd0));
      add_word(pack_word(FUNC_LOAD,  7'd0, 1'b1, 1'b1, 16'sd0));
      add_word(pack_word(FUNC_TRAIN, 7'd0, 1'b0, 1'b0, 16'sh8000));
      add_word(pack_word(FUNC_TRAIN, 7'd1, 1'b0, 1'b0, 16'sh7fff));
      add_word(pack_word(FUNC_LOAD,  7'd1, 1'b0, 1'b1, 16'sd0));
      add_word(pack_word(FUNC_LOAD,  7'd0, 1'b0, 1'b0, 16'sd0));
      add_word(pack_word(FUNC_TRAIN, 7'd0, 1'b0, 1'b0, 16'sh7fff));
      add_word(pack_word(FUNC_TRAIN, 7'd1, 1'b0, 1'b0, 16'sh8000));
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result receiver: random stall bursts, plus one long hold on request.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (stall_enable && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 19);
        end
      end
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    unit_result_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with nothing awaited", longint'(out_if.local_field), 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_if.unit_state !== want.unit_state) begin
          flag_mismatch("unit_state", longint'(out_if.unit_state), longint'(want.unit_state));
        end
        if (out_if.changed !== want.changed) begin
          flag_mismatch("changed", longint'(out_if.changed), longint'(want.changed));
        end
        if (out_if.error_made !== want.error_made) begin
          flag_mismatch("error_made", longint'(out_if.error_made), longint'(want.error_made));
        end
        if (out_if.local_field !== want.local_field) begin
          flag_mismatch("local_field", longint'(out_if.local_field),
                        longint'(want.local_field));
        end
        results_checked++;
      end
    end
  end

  // Stimulus: opening table, then phases through several register settings.
  initial begin : stimulus
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.func        <= FUNC_NOP;
    in_if.unit_index  <= '0;
    in_if.cue_bit     <= 1'b0;
    in_if.target_bit  <= 1'b0;
    in_if.field_noise <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_UNITS;
    cfg_if.data       <= '0;
    foreach (syn_weight[a, b]) syn_weight[a][b] = '0;
    cue_state    = '0;
    target_state = '0;
    cfg_units    = UNITS_RST;
    cfg_rate     = RATE_RST;
    stall_enable = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first words wait out the weight clear behind in_i.ready.
    foreach (opening_rows[r]) begin
      offer_word(opening_rows[r].word, opening_rows[r].typed, opening_rows[r].want);
    end
    in_if.valid <= 1'b0;

    // Small network; the receiver holds off long enough to back up the input.
    configure(8'd8, RATE_RST, 1'b1);
    hold_pending = 1'b1;
    build_mixed(220);
    drive_all();

    // No active unit: relax and train touch nothing.
    configure(8'd0, 8'd0, 1'b0);
    build_mixed(40);
    drive_all();

    // Single active unit, no idling on either side.
    stall_enable = 1'b0;
    configure(8'd1, 8'd128, 1'b0);
    build_mixed(40);
    drive_all();

    // Weight clamping at the top learning rate.
    stall_enable = 1'b1;
    configure(8'd2, 8'd255, 1'b0);
    build_saturation(68);
    drive_all();

    // Full network at the top rate.
    configure(8'd128, 8'd255, 1'b0);
    build_mixed(400);
    drive_all();

    // A unit count above the maximum acts as the maximum.
    configure(8'd200, 8'd3, 1'b1);
    build_mixed(60);
    drive_all();

    // Closing stretch without any idling.
    stall_enable = 1'b0;
    configure(8'd16, 8'd7, 1'b0);
    build_mixed(200);
    drive_all();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d loads, %0d relaxes, %0d trains (%0d row updates, %0d clamped %s",
             n_loads, n_relaxes, n_trains, n_row_updates, n_clamps, "weights)");
    $display("and %0d no-ops; %0d result words compared across %0d register writes, %0d %s",
             n_nops, results_checked, reg_writes, mismatch_count, "mismatches");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("timed out with %0d results outstanding", awaited_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

// File: hopfield_delta_rule_unit_engine.f
src/hdru_pkg.sv
src/hdru_if.sv
src/hdru_ram.sv
src/hopfield_delta_rule_unit_engine.sv
bench/tb_top.sv
